/* rtl/depth_pixel_unproject_to_world_macros.svh */
// Assertion macros for the depth back-projection block.
// Used by the top level only; assertions compile away when SYNTH is defined.
`ifndef DEPTH_PIXEL_UNPROJECT_TO_WORLD_MACROS_SVH
`define DEPTH_PIXEL_UNPROJECT_TO_WORLD_MACROS_SVH
`ifndef SYNTH
// Checked property, disabled while reset is asserted.
`define DPU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Checked property that also holds during reset.
`define DPU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define DPU_ASSERT(lbl, prop, msg)
`define DPU_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

/* rtl/dpu_pkg.sv */
// Shared types, register codes and saturation helpers for the back-projection block.
// No dependencies; used by every module of the block.
package dpu_pkg;

  // Input pixel request.
  typedef struct packed {
    logic [11:0] pix_col;
    logic [11:0] pix_row;
    logic [23:0] depth_value;
    logic [2:0]  conv_state;
    logic [7:0]  mask_value;
    logic [7:0]  gray_level;
    logic [7:0]  red_level;
    logic [7:0]  green_level;
    logic [7:0]  blue_level;
  } pix_in_t;

  // Output world point request.
  typedef struct packed {
    logic signed [23:0] world_x;
    logic signed [23:0] world_y;
    logic signed [23:0] world_z;
    logic [23:0]        point_attribute;
  } point_out_t;

  localparam int APB_ADDR_W  = 6;
  localparam int APB_DATA_W  = 64;
  localparam int ISQRT_STAGES = 32;
  localparam int DIV_STAGES   = 24;

  // Register indexes (byte address is eight times the index).
  localparam logic [2:0] REG_FOCAL = 3'd0;
  localparam logic [2:0] REG_PP    = 3'd1;
  localparam logic [2:0] REG_ROT0  = 3'd2;
  localparam logic [2:0] REG_ROT1  = 3'd3;
  localparam logic [2:0] REG_ROT2  = 3'd4;
  localparam logic [2:0] REG_TRANS = 3'd5;
  localparam logic [2:0] REG_CONV  = 3'd6;
  localparam logic [2:0] REG_MODE  = 3'd7;

  localparam logic signed [34:0] RAY_LIM = 35'sd2147483647;
  localparam logic signed [29:0] OUT_MAX = 30'sd8388607;
  localparam logic signed [29:0] OUT_MIN = -30'sd8388608;

  // Round a ray product to Q.16 and clamp it to the 32-bit symmetric range.
  function automatic logic signed [31:0] sat_ray(input logic signed [46:0] prod);
    logic signed [46:0] t;
    logic signed [34:0] s;
    t = prod + 47'sd2048;
    s = 35'(t >>> 12);
    if (s > RAY_LIM) begin
      return 32'(RAY_LIM);
    end else if (s < -RAY_LIM) begin
      return 32'(-RAY_LIM);
    end
    return 32'(s);
  endfunction

  // Round a rotated sum by 14 bits, add the offset and clamp to 24 bits.
  function automatic logic signed [23:0] sat_world(input logic signed [42:0] acc,
                                                   input logic signed [20:0] tr);
    logic signed [42:0] t;
    logic signed [28:0] s;
    logic signed [29:0] w;
    t = acc + 43'sd8192;
    s = 29'(t >>> 14);
    w = 30'(s) + 30'(tr);
    if (w > OUT_MAX) begin
      return 24'(OUT_MAX);
    end else if (w < OUT_MIN) begin
      return 24'(OUT_MIN);
    end
    return 24'(w);
  endfunction

endpackage

/* rtl/dpu_isqrt.sv */
// Pipelined integer square root, one result bit per stage.
// Uses dpu_pkg for the stage count; carries a side word along with each request.
module dpu_isqrt #(
  parameter int SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              vld_i,
  input  logic [63:0]       rad_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              vld_o,
  output logic [31:0]       root_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam int N = dpu_pkg::ISQRT_STAGES;

  logic [63:0]       rem_q  [N];
  logic [63:0]       res_q  [N];
  logic [SIDE_W-1:0] side_q [N];
  logic [N-1:0]      vld_q;

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [63:0]       rem_in;
    logic [63:0]       res_in;
    logic [SIDE_W-1:0] side_in;
    logic              vld_in;
    logic [63:0]       trial;
    logic [63:0]       rem_d;
    logic [63:0]       res_d;

    if (k == 0) begin : g_first
      assign rem_in  = rad_i;
      assign res_in  = '0;
      assign side_in = side_i;
      assign vld_in  = vld_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign res_in  = res_q[k-1];
      assign side_in = side_q[k-1];
      assign vld_in  = vld_q[k-1];
    end

    // Try the next root bit against the remaining radicand.
    always_comb begin
      trial = res_in + (64'd1 << (62 - 2 * k));
      if (rem_in >= trial) begin
        rem_d = rem_in - trial;
        res_d = (res_in >> 1) + (64'd1 << (62 - 2 * k));
      end else begin
        rem_d = rem_in;
        res_d = res_in >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= rem_d;
        res_q[k]  <= res_d;
        side_q[k] <= side_in;
      end
    end
  end

  assign vld_o  = vld_q[N-1];
  assign root_o = res_q[N-1][31:0];
  assign side_o = side_q[N-1];

endmodule

/* rtl/dpu_div.sv */
// Pipelined restoring divider, 56-bit numerator by 32-bit divisor, 24-bit quotient.
// The caller guarantees the quotient fits; uses dpu_pkg for the stage count.
module dpu_div #(
  parameter int SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              vld_i,
  input  logic [55:0]       num_i,
  input  logic [31:0]       den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              vld_o,
  output logic [23:0]       quo_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam int N = dpu_pkg::DIV_STAGES;

  logic [31:0]       rem_q  [N];
  logic [23:0]       low_q  [N];
  logic [23:0]       quo_q  [N];
  logic [31:0]       den_q  [N];
  logic [SIDE_W-1:0] side_q [N];
  logic [N-1:0]      vld_q;

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [31:0]       rem_in;
    logic [23:0]       low_in;
    logic [23:0]       quo_in;
    logic [31:0]       den_in;
    logic [SIDE_W-1:0] side_in;
    logic              vld_in;
    logic [32:0]       rem_sh;
    logic              ge;

    if (k == 0) begin : g_first
      assign rem_in  = num_i[55:24];
      assign low_in  = num_i[23:0];
      assign quo_in  = '0;
      assign den_in  = den_i;
      assign side_in = side_i;
      assign vld_in  = vld_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign low_in  = low_q[k-1];
      assign quo_in  = quo_q[k-1];
      assign den_in  = den_q[k-1];
      assign side_in = side_q[k-1];
      assign vld_in  = vld_q[k-1];
    end

    // Bring down one numerator bit and subtract the divisor when it fits.
    assign rem_sh = {rem_in, low_in[23]};
    assign ge     = rem_sh >= {1'b0, den_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? 32'(rem_sh - {1'b0, den_in}) : rem_sh[31:0];
        low_q[k]  <= {low_in[22:0], 1'b0};
        quo_q[k]  <= {quo_in[22:0], ge};
        den_q[k]  <= den_in;
        side_q[k] <= side_in;
      end
    end
  end

  assign vld_o  = vld_q[N-1];
  assign quo_o  = quo_q[N-1];
  assign side_o = side_q[N-1];

endmodule

/* rtl/depth_pixel_unproject_to_world.sv */
// Top level of the depth pixel back-projection block: config registers and pipeline.
// Depends on dpu_pkg, dpu_isqrt, dpu_div and the assertion macro header.
//
// Usage:
//   Pixels enter on the in_valid_i/in_ready_o channel as one dpu_pkg::pix_in_t request
//   and world points leave on out_valid_o/out_ready_i as one dpu_pkg::point_out_t.
//   A pixel that is not converged, or is rejected by the mask in color mode,
//   produces no output; all others produce exactly one point, in order.
//   The path from acceptance to out_valid_o runs through the 32-stage square root and
//   the 24-stage dividers, each retiring one bit per stage. One pixel is accepted every
//   cycle while out_ready_i does not stall the pipeline.
//   The whole pipeline advances together: when a point waits at the output and
//   out_ready_i is low, every stage holds and in_ready_o drops; nothing is lost.
//   Registers are written over the APB port (64-bit data, register i at 8*i); the user
//   must do so only while no pixel is in flight, as the block does not enforce it. Reset
//   clears all configuration registers and valid bits; no clearing pass is needed.
`include "depth_pixel_unproject_to_world_macros.svh"

module depth_pixel_unproject_to_world #(
  parameter int COORD_BITS = 12
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  dpu_pkg::pix_in_t                    in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output dpu_pkg::point_out_t                 out_data_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [dpu_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [dpu_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [dpu_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                pready
);

  localparam logic [15:0] CoordMask = 16'((32'd1 << COORD_BITS) - 1);

  // Configuration registers.
  logic [47:0] focal_q;
  logic [31:0] pp_q;
  logic [47:0] rot0_q, rot1_q, rot2_q;
  logic [62:0] trans_q;
  logic [2:0]  conv_q;
  logic        mode_q;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      focal_q <= '0;
      pp_q    <= '0;
      rot0_q  <= '0;
      rot1_q  <= '0;
      rot2_q  <= '0;
      trans_q <= '0;
      conv_q  <= '0;
      mode_q  <= 1'b0;
    end else if (wr_en) begin
      case (paddr[5:3])
        dpu_pkg::REG_FOCAL: focal_q <= pwdata[47:0];
        dpu_pkg::REG_PP:    pp_q    <= pwdata[31:0];
        dpu_pkg::REG_ROT0:  rot0_q  <= pwdata[47:0];
        dpu_pkg::REG_ROT1:  rot1_q  <= pwdata[47:0];
        dpu_pkg::REG_ROT2:  rot2_q  <= pwdata[47:0];
        dpu_pkg::REG_TRANS: trans_q <= pwdata[62:0];
        dpu_pkg::REG_CONV:  conv_q  <= pwdata[2:0];
        dpu_pkg::REG_MODE:  mode_q  <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Register read back.
  always_comb begin
    case (paddr[5:3])
      dpu_pkg::REG_FOCAL: prdata = {16'd0, focal_q};
      dpu_pkg::REG_PP:    prdata = {32'd0, pp_q};
      dpu_pkg::REG_ROT0:  prdata = {16'd0, rot0_q};
      dpu_pkg::REG_ROT1:  prdata = {16'd0, rot1_q};
      dpu_pkg::REG_ROT2:  prdata = {16'd0, rot2_q};
      dpu_pkg::REG_TRANS: prdata = {1'b0, trans_q};
      dpu_pkg::REG_CONV:  prdata = {61'd0, conv_q};
      dpu_pkg::REG_MODE:  prdata = {63'd0, mode_q};
      default:            prdata = '0;
    endcase
  end

  // Global advance: every stage moves when the output can take a point.
  logic out_vld_q;
  logic en;
  logic keep;

  assign en         = !out_vld_q || out_ready_i;
  assign in_ready_o = en;
  assign keep       = (in_data_i.conv_state == conv_q) &&
                      (!mode_q || (in_data_i.mask_value == 8'd1));

  // Stage 1: offsets from the principal point and the attribute.
  logic [15:0]        colx, rowy;
  logic               s1_vld_q;
  logic signed [21:0] s1_dx_q, s1_dy_q;
  logic [23:0]        s1_depth_q, s1_attr_q;

  assign colx = {4'd0, in_data_i.pix_col} & CoordMask;
  assign rowy = {4'd0, in_data_i.pix_row} & CoordMask;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_dx_q    <= $signed({2'b00, colx, 4'd0}) - $signed({6'd0, pp_q[15:0]});
      s1_dy_q    <= $signed({2'b00, rowy, 4'd0}) - $signed({6'd0, pp_q[31:16]});
      s1_depth_q <= in_data_i.depth_value;
      s1_attr_q  <= mode_q ? {in_data_i.red_level, in_data_i.green_level,
                              in_data_i.blue_level}
                           : {16'd0, in_data_i.gray_level};
    end
  end

  // Stage 2: multiply by the focal reciprocals.
  logic               s2_vld_q;
  logic signed [46:0] s2_px_q, s2_py_q;
  logic [23:0]        s2_depth_q, s2_attr_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_px_q    <= 47'(s1_dx_q) * 47'($signed({1'b0, focal_q[23:0]}));
      s2_py_q    <= 47'(s1_dy_q) * 47'($signed({1'b0, focal_q[47:24]}));
      s2_depth_q <= s1_depth_q;
      s2_attr_q  <= s1_attr_q;
    end
  end

  // Stage 3: round and clamp the ray components.
  logic               s3_vld_q;
  logic signed [31:0] s3_u_q, s3_v_q;
  logic [23:0]        s3_depth_q, s3_attr_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_u_q     <= dpu_pkg::sat_ray(s2_px_q);
      s3_v_q     <= dpu_pkg::sat_ray(s2_py_q);
      s3_depth_q <= s2_depth_q;
      s3_attr_q  <= s2_attr_q;
    end
  end

  // Stage 4: squares of the ray components.
  logic               s4_vld_q;
  logic [61:0]        s4_su_q, s4_sv_q;
  logic signed [31:0] s4_u_q, s4_v_q;
  logic [23:0]        s4_depth_q, s4_attr_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_su_q    <= 62'(64'(s3_u_q) * 64'(s3_u_q));
      s4_sv_q    <= 62'(64'(s3_v_q) * 64'(s3_v_q));
      s4_u_q     <= s3_u_q;
      s4_v_q     <= s3_v_q;
      s4_depth_q <= s3_depth_q;
      s4_attr_q  <= s3_attr_q;
    end
  end

  // Stage 5: squared ray length, the third component contributes one squared.
  logic               s5_vld_q;
  logic [63:0]        s5_n_q;
  logic signed [31:0] s5_u_q, s5_v_q;
  logic [23:0]        s5_depth_q, s5_attr_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s5_n_q     <= 64'(s4_su_q) + 64'(s4_sv_q) + 64'h1_0000_0000;
      s5_u_q     <= s4_u_q;
      s5_v_q     <= s4_v_q;
      s5_depth_q <= s4_depth_q;
      s5_attr_q  <= s4_attr_q;
    end
  end

  // Valid bits of the front stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
      s5_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q <= in_valid_i && keep;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= s3_vld_q;
      s5_vld_q <= s4_vld_q;
    end
  end

  // Ray length by square root; the ray and pixel data ride alongside.
  localparam int SqSideW = 112;
  logic               sq_vld;
  logic [31:0]        sq_len;
  logic [SqSideW-1:0] sq_side;
  logic signed [31:0] sq_u, sq_v;
  logic [23:0]        sq_depth, sq_attr;

  dpu_isqrt #(
    .SIDE_W (SqSideW)
  ) u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (s5_vld_q),
    .rad_i  (s5_n_q),
    .side_i ({s5_u_q, s5_v_q, s5_depth_q, s5_attr_q}),
    .vld_o  (sq_vld),
    .root_o (sq_len),
    .side_o (sq_side)
  );

  assign {sq_u, sq_v, sq_depth, sq_attr} = sq_side;

  // Stage 6: magnitudes times depth.
  logic        s6_vld_q;
  logic [54:0] s6_mx_q, s6_my_q;
  logic [39:0] s6_mz_q;
  logic        s6_sx_q, s6_sy_q;
  logic [31:0] s6_len_q;
  logic [23:0] s6_attr_q;
  logic [30:0] mag_u, mag_v;

  assign mag_u = sq_u[31] ? 31'(-sq_u) : sq_u[30:0];
  assign mag_v = sq_v[31] ? 31'(-sq_v) : sq_v[30:0];

  always_ff @(posedge clk_i) begin
    if (en) begin
      s6_mx_q   <= 55'(mag_u) * 55'(sq_depth);
      s6_my_q   <= 55'(mag_v) * 55'(sq_depth);
      s6_mz_q   <= {sq_depth, 16'd0};
      s6_sx_q   <= sq_u[31];
      s6_sy_q   <= sq_v[31];
      s6_len_q  <= sq_len;
      s6_attr_q <= sq_attr;
    end
  end

  // Stage 7: add half the length for rounding.
  logic        s7_vld_q;
  logic [55:0] s7_nx_q, s7_ny_q, s7_nz_q;
  logic        s7_sx_q, s7_sy_q;
  logic [31:0] s7_len_q;
  logic [23:0] s7_attr_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s7_nx_q   <= 56'(s6_mx_q) + 56'(s6_len_q >> 1);
      s7_ny_q   <= 56'(s6_my_q) + 56'(s6_len_q >> 1);
      s7_nz_q   <= 56'(s6_mz_q) + 56'(s6_len_q >> 1);
      s7_sx_q   <= s6_sx_q;
      s7_sy_q   <= s6_sy_q;
      s7_len_q  <= s6_len_q;
      s7_attr_q <= s6_attr_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s6_vld_q <= 1'b0;
      s7_vld_q <= 1'b0;
    end else if (en) begin
      s6_vld_q <= sq_vld;
      s7_vld_q <= s6_vld_q;
    end
  end

  // Normalize each component by the ray length.
  logic        dv_vx, dv_vy, dv_vz;
  logic [23:0] dv_qx, dv_qy, dv_qz;
  logic        dv_sx, dv_sy;
  logic [23:0] dv_attr;

  dpu_div #(.SIDE_W(1)) u_div_x (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en), .vld_i (s7_vld_q),
    .num_i (s7_nx_q), .den_i (s7_len_q), .side_i (s7_sx_q),
    .vld_o (dv_vx), .quo_o (dv_qx), .side_o (dv_sx)
  );

  dpu_div #(.SIDE_W(1)) u_div_y (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en), .vld_i (s7_vld_q),
    .num_i (s7_ny_q), .den_i (s7_len_q), .side_i (s7_sy_q),
    .vld_o (dv_vy), .quo_o (dv_qy), .side_o (dv_sy)
  );

  dpu_div #(.SIDE_W(24)) u_div_z (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en), .vld_i (s7_vld_q),
    .num_i (s7_nz_q), .den_i (s7_len_q), .side_i (s7_attr_q),
    .vld_o (dv_vz), .quo_o (dv_qz), .side_o (dv_attr)
  );

  // Stage 8: signed camera point.
  logic               s8_vld_q;
  logic signed [24:0] s8_p_q [3];
  logic [23:0]        s8_attr_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s8_p_q[0] <= dv_sx ? -$signed({1'b0, dv_qx}) : $signed({1'b0, dv_qx});
      s8_p_q[1] <= dv_sy ? -$signed({1'b0, dv_qy}) : $signed({1'b0, dv_qy});
      s8_p_q[2] <= $signed({1'b0, dv_qz});
      s8_attr_q <= dv_attr;
    end
  end

  // Stage 9: rotation products.
  logic               s9_vld_q;
  logic signed [40:0] s9_m_q [3][3];
  logic [23:0]        s9_attr_q;
  logic [47:0]        rot_row [3];

  assign rot_row[0] = rot0_q;
  assign rot_row[1] = rot1_q;
  assign rot_row[2] = rot2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          s9_m_q[i][j] <= 41'($signed(rot_row[i][16*j +: 16])) * 41'(s8_p_q[j]);
        end
      end
      s9_attr_q <= s8_attr_q;
    end
  end

  // Stage 10: sum each row.
  logic               s10_vld_q;
  logic signed [42:0] s10_acc_q [3];
  logic [23:0]        s10_attr_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s10_acc_q[i] <= 43'(s9_m_q[i][0]) + 43'(s9_m_q[i][1]) + 43'(s9_m_q[i][2]);
      end
      s10_attr_q <= s9_attr_q;
    end
  end

  // Stage 11: round, translate, clamp into the output register.
  dpu_pkg::point_out_t out_data_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q.world_x <= dpu_pkg::sat_world(s10_acc_q[0], $signed(trans_q[20:0]));
      out_data_q.world_y <= dpu_pkg::sat_world(s10_acc_q[1], $signed(trans_q[41:21]));
      out_data_q.world_z <= dpu_pkg::sat_world(s10_acc_q[2], $signed(trans_q[62:42]));
      out_data_q.point_attribute <= s10_attr_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s8_vld_q  <= 1'b0;
      s9_vld_q  <= 1'b0;
      s10_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      s8_vld_q  <= dv_vx && dv_vy && dv_vz;
      s9_vld_q  <= s8_vld_q;
      s10_vld_q <= s9_vld_q;
      out_vld_q <= s10_vld_q;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_data_q;

  // The ray length can never fall below one in Q.16.
  `DPU_ASSERT(a_len_min, sq_vld |-> (sq_len >= 32'd65536), "ray length below one")
  // The z quotient must fit: its numerator's upper part stays below the length.
  `DPU_ASSERT(a_div_fit, s7_vld_q |-> (s7_nz_q[55:24] < s7_len_q), "quotient overflow")
  // All three dividers stay in step.
  `DPU_ASSERT(a_div_sync, (dv_vx == dv_vy) && (dv_vy == dv_vz), "dividers out of step")
  // The register port never waits, in reset or out of it.
  `DPU_ASSERT_ALWAYS(a_pready_high, pready, "register port not ready")

endmodule
